[rtl/frur_pkg.sv]
// ----------------------------------------------------------------------------
// frur_pkg
// Types and constants shared by the unpolarized Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package frur_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SHARED_MODE = 2'd0;
  localparam logic [1:0] CFG_SHARED_N1   = 2'd1;
  localparam logic [1:0] CFG_SHARED_N2   = 2'd2;

  localparam logic [15:0] INDEX_ONE = 16'd4096;   // 1.0 in Q4.12
  localparam logic [15:0] REFL_ONE  = 16'd32768;  // 1.0 in Q1.15

  localparam int SQRT_STAGES = 32;  // one result bit per stage
  localparam int DIV_STAGES  = 30;  // one quotient bit per stage
  localparam int RAD_W       = 63;  // radicand width
  localparam int ROOT_W      = 32;
  localparam int DIV_W       = 49;  // widest numerator / denominator

  typedef struct packed {
    logic [15:0]        n_incident;
    logic [15:0]        n_transmit;
    logic signed [15:0] cos_theta;
    logic               end_of_batch;
  } frur_in_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
    logic        batch_end;
  } frur_out_t;

  // side data that travels beside the square root stages
  typedef struct packed {
    logic        v;
    logic        pos_c;
    logic        tir;
    logic        eob;
    logic [30:0] p;
    logic [15:0] n1;
    logic [31:0] n2sq;
    logic [14:0] c;
  } frur_sb1_t;

  // side data that travels beside the divider stages
  typedef struct packed {
    logic v;
    logic pos_c;
    logic tir;
    logic zero;
    logic one_s;
    logic one_p;
    logic eob;
  } frur_sb2_t;

endpackage

[rtl/frur_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// frur_sqrt_pipe
// Pipelined integer square root, floor(sqrt(d)), one root bit per stage.
// ----------------------------------------------------------------------------
module frur_sqrt_pipe
  import frur_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  d_i,
  output logic [ROOT_W-1:0] s_o
);

  logic [63:0] x_r   [SQRT_STAGES];
  logic [63:0] res_r [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] x_in, res_in, trial;

    always_comb begin
      if (i == 0) begin
        x_in   = {1'b0, d_i};
        res_in = '0;
      end else begin
        x_in   = x_r[(i == 0) ? 0 : i - 1];
        res_in = res_r[(i == 0) ? 0 : i - 1];
      end
      trial = res_in + BIT;
    end

    // restoring step: subtract the trial value when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= trial) begin
          x_r[i]   <= x_in - trial;
          res_r[i] <= (res_in >> 1) + BIT;
        end else begin
          x_r[i]   <= x_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign s_o = res_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

[rtl/frur_div_pipe.sv]
// ----------------------------------------------------------------------------
// frur_div_pipe
// Pipelined fractional divider: floor(num/den * 2^30) for num < den.
// ----------------------------------------------------------------------------
module frur_div_pipe
  import frur_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [DIV_W-1:0]      num_i,
  input  logic [DIV_W-1:0]      den_i,
  output logic [DIV_STAGES-1:0] q_o
);

  logic [DIV_W-1:0]      rem_r [DIV_STAGES];
  logic [DIV_W-1:0]      den_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] q_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [DIV_W-1:0]      rem_in, den_in;
    logic [DIV_STAGES-1:0] q_in;
    logic [DIV_W:0]        rem2;

    always_comb begin
      if (i == 0) begin
        rem_in = num_i;
        den_in = den_i;
        q_in   = '0;
      end else begin
        rem_in = rem_r[(i == 0) ? 0 : i - 1];
        den_in = den_r[(i == 0) ? 0 : i - 1];
        q_in   = q_r[(i == 0) ? 0 : i - 1];
      end
      rem2 = {rem_in, 1'b0};
    end

    // one restoring division step
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in;
        if (rem2 >= {1'b0, den_in}) begin
          rem_r[i] <= DIV_W'(rem2 - {1'b0, den_in});
          q_r[i]   <= {q_in[DIV_STAGES-2:0], 1'b1};
        end else begin
          rem_r[i] <= rem2[DIV_W-1:0];
          q_r[i]   <= {q_in[DIV_STAGES-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o = q_r[DIV_STAGES-1];

endmodule

[rtl/fresnel_unpolarized_reflectance_core.sv]
// ----------------------------------------------------------------------------
// fresnel_unpolarized_reflectance_core
// Unpolarized Fresnel reflectance, fully pipelined, one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Input items (indices Q4.12, cosine signed Q2.14) arrive on in_valid/in_ready;
// results (reflectance Q1.15, total internal flag, batch end copy) leave on
// out_valid/out_ready. Each transfer moves one item.
// The cfg port writes shared_mode and the two shared indices; in shared mode
// the item's own index fields are ignored. Write it only while idle.
// From input transfer to out_valid an item passes 5 front stages of
// multiplies and the radicand, 32 square root stages (one root bit each),
// 2 stages for the ratio terms, 30 divider stages (one quotient bit each)
// and 3 stages of squaring, rounding and output selection.
// Throughput is one item per cycle. When out_ready is low with a result
// waiting, the whole pipeline holds and in_ready drops; no item is lost or
// repeated. Reset (rst_n low, synchronous) clears all valid bits and sets
// the registers to shared_mode 0 and both shared indices to 1.0.
// ----------------------------------------------------------------------------
module fresnel_unpolarized_reflectance_core
  import frur_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  frur_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output frur_out_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic        en;
  logic        shared_mode_r;
  logic [15:0] shared_n1_r, shared_n2_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_mode_r <= 1'b0;
      shared_n1_r   <= INDEX_ONE;
      shared_n2_r   <= INDEX_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHARED_MODE: shared_mode_r <= cfg_wdata[0];
        CFG_SHARED_N1:   shared_n1_r   <= cfg_wdata;
        CFG_SHARED_N2:   shared_n2_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: hold everything while a result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: index select, cosine classification
  logic        va_r, posc_a_r, eob_a_r;
  logic [15:0] n1_a_r, n2_a_r;
  logic [14:0] c_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_a_r   <= shared_mode_r ? shared_n1_r : in_data.n_incident;
      n2_a_r   <= shared_mode_r ? shared_n2_r : in_data.n_transmit;
      c_a_r    <= in_data.cos_theta[14:0];
      posc_a_r <= !in_data.cos_theta[15] && (in_data.cos_theta != 16'sd0);
      eob_a_r  <= in_data.end_of_batch;
    end
  end

  // stage B: products of the indices and cosine
  logic        vb_r, posc_b_r, eob_b_r;
  logic [30:0] p_b_r;
  logic [31:0] n1sq_b_r, n2sq_b_r;
  logic [15:0] n1_b_r;
  logic [14:0] c_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_b_r    <= n1_a_r * c_a_r;
      n1sq_b_r <= n1_a_r * n1_a_r;
      n2sq_b_r <= n2_a_r * n2_a_r;
      n1_b_r   <= n1_a_r;
      c_b_r    <= c_a_r;
      posc_b_r <= posc_a_r;
      eob_b_r  <= eob_a_r;
    end
  end

  // stage C: P squared
  logic        vc_r, posc_c_r, eob_c_r;
  logic [61:0] pp_c_r;
  logic [30:0] p_c_r;
  logic [31:0] n1sq_c_r, n2sq_c_r;
  logic [15:0] n1_c_r;
  logic [14:0] c_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_c_r   <= p_b_r * p_b_r;
      p_c_r    <= p_b_r;
      n1sq_c_r <= n1sq_b_r;
      n2sq_c_r <= n2sq_b_r;
      n1_c_r   <= n1_b_r;
      c_c_r    <= c_b_r;
      posc_c_r <= posc_b_r;
      eob_c_r  <= eob_b_r;
    end
  end

  // stage D: positive part of the radicand
  logic        vd_r, posc_d_r, eob_d_r;
  logic [62:0] pos_d_r;
  logic [59:0] neg_d_r;
  logic [30:0] p_d_r;
  logic [31:0] n2sq_d_r;
  logic [15:0] n1_d_r;
  logic [14:0] c_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (en) vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_d_r  <= {3'b0, n2sq_c_r, 28'b0} + {1'b0, pp_c_r};
      neg_d_r  <= {n1sq_c_r, 28'b0};
      p_d_r    <= p_c_r;
      n2sq_d_r <= n2sq_c_r;
      n1_d_r   <= n1_c_r;
      c_d_r    <= c_c_r;
      posc_d_r <= posc_c_r;
      eob_d_r  <= eob_c_r;
    end
  end

  // stage E: radicand and total internal reflection test
  logic [62:0] d_e_r;
  frur_sb1_t   sb_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb_e_r.v <= 1'b0;
    else if (en) sb_e_r.v <= vd_r;
    if (en) begin
      d_e_r        <= pos_d_r - {3'b0, neg_d_r};
      sb_e_r.tir   <= pos_d_r < {3'b0, neg_d_r};
      sb_e_r.pos_c <= posc_d_r;
      sb_e_r.eob   <= eob_d_r;
      sb_e_r.p     <= p_d_r;
      sb_e_r.n1    <= n1_d_r;
      sb_e_r.n2sq  <= n2sq_d_r;
      sb_e_r.c     <= c_d_r;
    end
  end

  // square root and its matching side line
  logic [ROOT_W-1:0] s_root;
  frur_sb1_t         sb1_r [SQRT_STAGES];

  frur_sqrt_pipe u_sqrt (
    .clk (clk),
    .en  (en),
    .d_i (d_e_r),
    .s_o (s_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_STAGES; i++) sb1_r[i].v <= 1'b0;
    end else if (en) begin
      sb1_r[0] <= sb_e_r;
      for (int i = 1; i < SQRT_STAGES; i++) sb1_r[i] <= sb1_r[i-1];
    end
  end

  frur_sb1_t sb1_last;
  assign sb1_last = sb1_r[SQRT_STAGES-1];

  // stage F: ratio terms
  logic        vf_r, posc_f_r, tir_f_r, eob_f_r;
  logic [47:0] a_f_r;
  logic [46:0] b_f_r;
  logic [32:0] num1_f_r, den1_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (en) vf_r <= sb1_last.v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f_r    <= sb1_last.n1 * s_root;
      b_f_r    <= sb1_last.n2sq * sb1_last.c;
      num1_f_r <= ({2'b0, sb1_last.p} >= {1'b0, s_root})
                  ? {2'b0, sb1_last.p} - {1'b0, s_root}
                  : {1'b0, s_root} - {2'b0, sb1_last.p};
      den1_f_r <= {2'b0, sb1_last.p} + {1'b0, s_root};
      posc_f_r <= sb1_last.pos_c;
      tir_f_r  <= sb1_last.tir;
      eob_f_r  <= sb1_last.eob;
    end
  end

  // stage G: p ratio terms, ratio-of-one and zero denominator flags
  logic [DIV_W-1:0] num1_g_r, den1_g_r, num2_g_r, den2_g_r;
  frur_sb2_t        sb_g_r;
  logic [48:0]      a_ext, b_ext, num2_w, den2_w;

  assign a_ext  = {1'b0, a_f_r};
  assign b_ext  = {2'b0, b_f_r};
  assign num2_w = (a_ext >= b_ext) ? a_ext - b_ext : b_ext - a_ext;
  assign den2_w = a_ext + b_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) sb_g_r.v <= 1'b0;
    else if (en) sb_g_r.v <= vf_r;
    if (en) begin
      num1_g_r     <= {16'b0, num1_f_r};
      den1_g_r     <= {16'b0, den1_f_r};
      num2_g_r     <= num2_w;
      den2_g_r     <= den2_w;
      sb_g_r.one_s <= num1_f_r >= den1_f_r;
      sb_g_r.one_p <= num2_w >= den2_w;
      sb_g_r.zero  <= (den1_f_r == '0) || (den2_w == '0);
      sb_g_r.pos_c <= posc_f_r;
      sb_g_r.tir   <= tir_f_r;
      sb_g_r.eob   <= eob_f_r;
    end
  end

  // dividers for both ratios and their side line
  logic [DIV_STAGES-1:0] qs_div, qp_div;
  frur_sb2_t             sb2_r [DIV_STAGES];

  frur_div_pipe u_div_s (
    .clk   (clk),
    .en    (en),
    .num_i (num1_g_r),
    .den_i (den1_g_r),
    .q_o   (qs_div)
  );

  frur_div_pipe u_div_p (
    .clk   (clk),
    .en    (en),
    .num_i (num2_g_r),
    .den_i (den2_g_r),
    .q_o   (qp_div)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) sb2_r[i].v <= 1'b0;
    end else if (en) begin
      sb2_r[0] <= sb_g_r;
      for (int i = 1; i < DIV_STAGES; i++) sb2_r[i] <= sb2_r[i-1];
    end
  end

  frur_sb2_t sb2_last;
  assign sb2_last = sb2_r[DIV_STAGES-1];

  // stage H: quotients, a ratio of one reads as 2^30
  logic [DIV_STAGES:0] qs_h_r, qp_h_r;
  frur_sb2_t           sb_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb_h_r.v <= 1'b0;
    else if (en) sb_h_r.v <= sb2_last.v;
    if (en) begin
      qs_h_r       <= sb2_last.one_s ? {1'b1, {DIV_STAGES{1'b0}}} : {1'b0, qs_div};
      qp_h_r       <= sb2_last.one_p ? {1'b1, {DIV_STAGES{1'b0}}} : {1'b0, qp_div};
      sb_h_r.one_s <= sb2_last.one_s;
      sb_h_r.one_p <= sb2_last.one_p;
      sb_h_r.zero  <= sb2_last.zero;
      sb_h_r.pos_c <= sb2_last.pos_c;
      sb_h_r.tir   <= sb2_last.tir;
      sb_h_r.eob   <= sb2_last.eob;
    end
  end

  // stage I: squares of the ratios
  logic [61:0] sqs_i_r, sqp_i_r;
  frur_sb2_t   sb_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb_i_r.v <= 1'b0;
    else if (en) sb_i_r.v <= sb_h_r.v;
    if (en) begin
      sqs_i_r      <= qs_h_r * qs_h_r;
      sqp_i_r      <= qp_h_r * qp_h_r;
      sb_i_r.one_s <= sb_h_r.one_s;
      sb_i_r.one_p <= sb_h_r.one_p;
      sb_i_r.zero  <= sb_h_r.zero;
      sb_i_r.pos_c <= sb_h_r.pos_c;
      sb_i_r.tir   <= sb_h_r.tir;
      sb_i_r.eob   <= sb_h_r.eob;
    end
  end

  // stage J: mean with rounding, clamp, special cases, output register
  logic [62:0] sum_w;
  logic [15:0] r_w, refl_w;
  logic        tir_w;
  logic        out_valid_r;
  frur_out_t   out_data_r;

  always_comb begin
    sum_w = {1'b0, sqs_i_r} + {1'b0, sqp_i_r} + (63'd1 << 45);
    r_w   = sum_w[61:46];
    tir_w = 1'b0;
    if (!sb_i_r.pos_c) begin
      refl_w = '0;
    end else if (sb_i_r.tir) begin
      refl_w = REFL_ONE;
      tir_w  = 1'b1;
    end else if (sb_i_r.zero) begin
      refl_w = REFL_ONE;
    end else if (r_w > REFL_ONE) begin
      refl_w = REFL_ONE;
    end else begin
      refl_w = r_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= sb_i_r.v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.reflectance    <= refl_w;
      out_data_r.total_internal <= tir_w;
      out_data_r.batch_end      <= sb_i_r.eob;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_tir_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.total_internal |-> out_data.reflectance == REFL_ONE)
    else $error("total internal result not full reflectance");

  a_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.reflectance <= REFL_ONE)
    else $error("reflectance above one");

  a_hold_front : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(va_r) && $stable(sb_e_r.v))
    else $error("pipeline advanced during stall");

endmodule

[dv/tb_fresnel_unpolarized_reflectance_core.sv]
// ----------------------------------------------------------------------------
// tb_fresnel_unpolarized_reflectance_core
// Self-checking bench for the unpolarized Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
// Items are sent on the input channel with random gaps. Each transfer is
// predicted with an exact integer model of the reflectance. Results are
// compared field by field against the oldest expected result, while the
// result side stalls at random. Directed cases cover the cosine and index
// extremes and total internal reflection. Later phases cover shared-index
// mode, register masking and an ignored register index, then random traffic
// under several register settings.
// ----------------------------------------------------------------------------
module tb_fresnel_unpolarized_reflectance_core;
  import frur_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index with no register behind it
  localparam int PIPE_LATENCY = 72;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  frur_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  frur_out_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  // shadow copy of the block's registers
  logic        shadow_mode;
  logic [15:0] shadow_n1;
  logic [15:0] shadow_n2;

  frur_out_t pending_refl[$];
  int        error_count;
  bit        steady_flow;  // phase with no gaps or stalls
  int        stall_left;

  fresnel_unpolarized_reflectance_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // floor of the square root
  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // floor(num/den * 2^30), saturating at 1.0
  function automatic longint unsigned frac_q30(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned rem;
    longint unsigned q;
    if (num >= den) return 64'd1 << 30;
    rem = num;
    q = 0;
    for (int i = 0; i < 30; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  // expected result for one input item under the current registers
  function automatic frur_out_t predict_reflectance(input frur_in_t it);
    frur_out_t res;
    longint unsigned n1, n2, c, n2sq, p, pos, neg, s, a, b;
    longint unsigned num1, den1, num2, den2, qs, qp, r;
    logic [15:0] craw;
    res = '0;
    res.batch_end = it.end_of_batch;
    n1 = shadow_mode ? shadow_n1 : it.n_incident;
    n2 = shadow_mode ? shadow_n2 : it.n_transmit;
    craw = it.cos_theta;
    // non-positive cosine gives zero reflectance
    if (craw == 16'd0 || craw[15]) return res;
    c = craw;
    n2sq = n2 * n2;
    p = n1 * c;
    pos = (n2sq << 28) + p * p;
    neg = (n1 * n1) << 28;
    if (pos < neg) begin
      res.reflectance = REFL_ONE;
      res.total_internal = 1'b1;
      return res;
    end
    s = isqrt(pos - neg);
    num1 = (p >= s) ? p - s : s - p;
    den1 = p + s;
    a = n1 * s;
    b = n2sq * c;
    num2 = (a >= b) ? a - b : b - a;
    den2 = a + b;
    if (den1 == 0 || den2 == 0) begin
      res.reflectance = REFL_ONE;
      return res;
    end
    qs = frac_q30(num1, den1);
    qp = frac_q30(num2, den2);
    r = (qs * qs + qp * qp + (64'd1 << 45)) >> 46;
    res.reflectance = (r > REFL_ONE) ? REFL_ONE : r[15:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // send one item; valid stays high when the next item follows directly
  task automatic send_item(input frur_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_refl.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    go_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SHARED_MODE: shadow_mode = val[0];
      CFG_SHARED_N1:   shadow_n1 = val;
      CFG_SHARED_N2:   shadow_n2 = val;
      default: ;
    endcase
  endtask

  function automatic frur_in_t make_item(input logic [15:0] n1, input logic [15:0] n2,
                                         input logic [15:0] c, input logic eob);
    frur_in_t it;
    it.n_incident   = n1;
    it.n_transmit   = n2;
    it.cos_theta    = c;
    it.end_of_batch = eob;
    return it;
  endfunction

  function automatic logic [15:0] rand_index();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 16'($urandom_range(4096, 8192));
    if (roll < 8) return 16'($urandom_range(4096, 65535));
    if (roll < 9) return ($urandom_range(0, 1) != 0) ? INDEX_ONE : 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] rand_cos();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 16'($urandom_range(0, 16384));
    if (roll < 9) return 16'(-$urandom_range(0, 16384));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_item(make_item(rand_index(), rand_index(), rand_cos(),
                          1'($urandom_range(0, 1))));
  endtask

  // input transfers: predict
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      pending_refl.push_back(predict_reflectance(in_data));
  end

  // result transfers: check against the oldest expectation
  always @(posedge clk) begin
    frur_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_refl.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_r = pending_refl.pop_front();
        if (out_data.reflectance !== exp_r.reflectance)
          report_mismatch($sformatf("reflectance %0d, expected %0d",
                                    out_data.reflectance, exp_r.reflectance));
        if (out_data.total_internal !== exp_r.total_internal)
          report_mismatch($sformatf("total_internal %b, expected %b",
                                    out_data.total_internal, exp_r.total_internal));
        if (out_data.batch_end !== exp_r.batch_end)
          report_mismatch($sformatf("batch_end %b, expected %b",
                                    out_data.batch_end, exp_r.batch_end));
      end
    end
  end

  // result-side stalls
  always @(posedge clk) begin
    int roll;
    if (steady_flow) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_ready <= 1'b1;
      end else if (roll < 95) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  task automatic test_directed_per_item();
    send_item(make_item(INDEX_ONE, 16'd6144, 16'd0, 1'b0));        // zero cosine
    send_item(make_item(INDEX_ONE, 16'd6144, 16'hFFFF, 1'b1));     // slightly negative
    send_item(make_item(INDEX_ONE, 16'd6144, -16'sd16384, 1'b0));  // -1.0
    send_item(make_item(INDEX_ONE, 16'd6144, 16'h8000, 1'b0));     // most negative
    send_item(make_item(INDEX_ONE, 16'd6144, 16'd16384, 1'b0));    // normal incidence
    send_item(make_item(INDEX_ONE, 16'd6144, 16'd1, 1'b1));        // grazing
    send_item(make_item(INDEX_ONE, 16'd6144, 16'h7FFF, 1'b0));     // cosine above 1.0
    send_item(make_item(INDEX_ONE, INDEX_ONE, 16'd9000, 1'b0));    // matched media
    send_item(make_item(16'hFFFF, 16'hFFFF, 16'd16384, 1'b0));
    send_item(make_item(16'hFFFF, INDEX_ONE, 16'd100, 1'b1));      // total internal reflection
    send_item(make_item(16'hFFFF, INDEX_ONE, 16'd16384, 1'b0));
    send_item(make_item(16'hFFFF, INDEX_ONE, 16'h7FFF, 1'b0));
    send_item(make_item(INDEX_ONE, 16'hFFFF, 16'd1, 1'b0));
    send_item(make_item(INDEX_ONE, 16'hFFFF, 16'h7FFF, 1'b1));
    send_item(make_item(16'd6144, INDEX_ONE, 16'd8000, 1'b0));     // near critical angle
    send_item(make_item(16'd6144, INDEX_ONE, 16'd12000, 1'b0));
    send_item(make_item(16'd0, 16'd0, 16'd16384, 1'b0));           // zero denominator
    send_item(make_item(16'd2048, 16'd1000, 16'd5000, 1'b1));      // indices below 1.0
  endtask

  task automatic test_shared_mode();
    write_reg(CFG_SHARED_N1, 16'hFFFF);
    write_reg(CFG_SHARED_N2, INDEX_ONE);
    write_reg(CFG_SHARED_MODE, 16'd1);
    send_random(15);
    write_reg(CFG_SHARED_N1, INDEX_ONE);
    write_reg(CFG_SHARED_N2, 16'hFFFF);
    send_random(15);
  endtask

  task automatic test_register_masking();
    write_reg(CFG_SHARED_MODE, 16'hFFFE);  // only bit 0 counts: back to per-item
    write_reg(CFG_UNUSED, 16'h1234);       // no register there
    send_random(10);
    write_reg(CFG_SHARED_MODE, 16'hFFFF);
    send_random(10);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_SHARED_MODE, 16'($urandom_range(0, 1)));
      write_reg(CFG_SHARED_N1, rand_index());
      write_reg(CFG_SHARED_N2, rand_index());
      steady_flow = (phase == 3);
      send_random(60);
      steady_flow = 1'b0;
    end
  endtask

  // watchdog
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    error_count = 0;
    steady_flow = 1'b0;
    stall_left  = 0;
    shadow_mode = 1'b0;
    shadow_n1   = INDEX_ONE;
    shadow_n2   = INDEX_ONE;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SHARED_MODE;
    cfg_wdata   = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_per_item();
    test_shared_mode();
    test_register_masking();
    test_random_traffic();

    go_idle();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (pending_refl.size() != 0) begin
      report_mismatch("expected results left over");
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
